// ----- design/ffa_pkg.sv -----
// Shared constants and types of the first-fit allocator.
`timescale 1ns / 1ps
package ffa_pkg;

   // Default geometry.
   localparam int HEAP_BYTES_DEFAULT   = 65536;
   localparam int MAX_EXTENTS_DEFAULT  = 64;
   localparam int HEADER_BYTES_DEFAULT = 8;

   // Field and register widths.
   localparam int REQ_W   = 16;
   localparam int GROW_W  = 17;
   localparam int FRAG_W  = 11;
   localparam int CSR_W   = 17;
   localparam int CSR_IW  = 1;

   // Configuration register reset values.
   localparam logic [GROW_W-1:0] GROW_RESET = 17'd8192;
   localparam logic [FRAG_W-1:0] FRAG_RESET = 11'd16;

   typedef logic [1:0] status_type;
   typedef logic [CSR_IW-1:0] csr_index_type;

   // Result status codes.
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NOMEM   = 2'd1;
   localparam status_type ST_BADFREE = 2'd2;
   localparam status_type ST_FULL    = 2'd3;

   // Configuration register indexes.
   localparam csr_index_type CSR_GROW_MIN = 1'd0;
   localparam csr_index_type CSR_MIN_FRAG = 1'd1;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

endpackage

// ----- design/first_fit_free_list_allocator_unit.sv -----
// First-fit heap allocator with an address-ordered, coalescing free extent table.
`timescale 1ns / 1ps
// Each request word is handled by a sequencer around two memories: the free extent table
// (MAX_EXTENTS entries of start and length) and a per-slot table of block length and live
// mark (HEAP_BYTES / 8 entries). An allocate scans the extent table, reading and then
// testing one entry at a time, and a free scans it for its insertion point; removing or
// inserting an extent then moves the entries behind it, each read and then written. Scans
// and moves are paced by the single read port of the extent table. After reset the live
// marks of all HEAP_BYTES / 8 slots are swept clear, one slot per cycle, and no request
// word is taken during the sweep. A finished result word sits in an output register, so
// the next request is taken while it waits.
module first_fit_free_list_allocator_unit #(
   parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEFAULT,
   parameter int MAX_EXTENTS  = ffa_pkg::MAX_EXTENTS_DEFAULT,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [ffa_pkg::REQ_W-1:0]    req_request_bytes,
   input  logic [ffa_pkg::REQ_W-1:0]    req_block_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ffa_pkg::REQ_W-1:0]    rsp_result_address,
   output ffa_pkg::status_type          rsp_status,
   input  logic                         csr_write_enable,
   input  ffa_pkg::csr_index_type       csr_index,
   input  logic [ffa_pkg::CSR_W-1:0]    csr_write_data
);

   localparam int AW    = $clog2(HEAP_BYTES);
   localparam int LW    = (AW + 1 > ffa_pkg::GROW_W) ? AW + 1 : ffa_pkg::GROW_W;
   localparam int SLOTS = HEAP_BYTES / 8;
   localparam int SW    = $clog2(SLOTS);
   localparam int IW    = $clog2(MAX_EXTENTS);
   localparam int CW    = $clog2(MAX_EXTENTS + 1);
   localparam int EW    = 2 * LW;

   localparam logic [LW-1:0] HEAP_L   = LW'(HEAP_BYTES);
   localparam logic [LW-1:0] SLOTS_L  = LW'(SLOTS);
   localparam logic [LW-1:0] HDR_L    = LW'(HEADER_BYTES);
   localparam logic [CW-1:0] MAX_L    = CW'(MAX_EXTENTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   // Sequencer states.
   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_A_START  = 5'd2;
   localparam logic [4:0] S_A_SCAN   = 5'd3;
   localparam logic [4:0] S_A_TEST   = 5'd4;
   localparam logic [4:0] S_A_GROW   = 5'd5;
   localparam logic [4:0] S_A_MARK   = 5'd6;
   localparam logic [4:0] S_F_START  = 5'd7;
   localparam logic [4:0] S_F_CHECK  = 5'd8;
   localparam logic [4:0] S_P_SCAN   = 5'd9;
   localparam logic [4:0] S_P_TEST   = 5'd10;
   localparam logic [4:0] S_P_DECIDE = 5'd11;
   localparam logic [4:0] S_P_OK     = 5'd12;
   localparam logic [4:0] S_D_READ   = 5'd13;
   localparam logic [4:0] S_D_WRITE  = 5'd14;
   localparam logic [4:0] S_D_END    = 5'd15;
   localparam logic [4:0] S_U_READ   = 5'd16;
   localparam logic [4:0] S_U_WRITE  = 5'd17;
   localparam logic [4:0] S_U_END    = 5'd18;
   localparam logic [4:0] S_DONE     = 5'd19;

   // Memories.
   logic [EW-1:0] ext_mem [MAX_EXTENTS];
   logic [LW-1:0] blen_mem [SLOTS];
   logic          live_mem [SLOTS];

   logic [EW-1:0] ext_rd_ff;
   logic [LW-1:0] blen_rd_ff;
   logic          live_rd_ff;

   logic          ext_we;
   logic [IW-1:0] ext_waddr;
   logic [IW-1:0] ext_raddr;
   logic [EW-1:0] ext_wdata;
   logic          blen_we;
   logic          live_we;
   logic          live_wdata;
   logic [SW-1:0] slot_waddr;
   logic [SW-1:0] slot_raddr;

   // Registers.
   logic [4:0]                 state_ff, state_in;
   logic [SW-1:0]              clr_ff, clr_in;
   logic [ffa_pkg::GROW_W-1:0] grow_ff, grow_in;
   logic [ffa_pkg::FRAG_W-1:0] frag_ff, frag_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [LW-1:0]              top_ff, top_in;
   logic                       kind_ff, kind_in;
   logic [ffa_pkg::REQ_W-1:0]  rbytes_ff, rbytes_in;
   logic [ffa_pkg::REQ_W-1:0]  faddr_ff, faddr_in;
   logic [LW-1:0]              need_ff, need_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              j_ff, j_in;
   logic [LW-1:0]              blk_s_ff, blk_s_in;
   logic [LW-1:0]              blk_len_ff, blk_len_in;
   logic [LW-1:0]              glen_ff, glen_in;
   logic [LW-1:0]              ps_ff, ps_in;
   logic [LW-1:0]              plen_ff, plen_in;
   logic [EW-1:0]              prev_ff, prev_in;
   logic [EW-1:0]              cur_ff, cur_in;
   logic                       have_cur_ff, have_cur_in;
   logic                       in_put_ff, in_put_in;
   logic [ffa_pkg::REQ_W-1:0]  res_addr_ff, res_addr_in;
   ffa_pkg::status_type        res_st_ff, res_st_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ffa_pkg::REQ_W-1:0]  rsp_addr_ff, rsp_addr_in;
   ffa_pkg::status_type        rsp_st_ff, rsp_st_in;

   // Helper values.
   logic [LW-1:0] rd_start, rd_len;
   logic [LW-1:0] prev_s, prev_l, cur_s, cur_l;
   logic [LW-1:0] thresh;
   logic [LW-1:0] glen_c;
   logic [LW-1:0] fs_ext;
   logic [LW-1:0] fslot;
   logic [ffa_pkg::GROW_W-1:0] rounded;
   logic          prev_hit, next_hit;

   assign rd_start = ext_rd_ff[EW-1:LW];
   assign rd_len   = ext_rd_ff[LW-1:0];
   assign prev_s   = prev_ff[EW-1:LW];
   assign prev_l   = prev_ff[LW-1:0];
   assign cur_s    = cur_ff[EW-1:LW];
   assign cur_l    = cur_ff[LW-1:0];
   assign thresh   = LW'(frag_ff) + HDR_L;
   assign glen_c   = (need_ff > LW'(grow_ff)) ? need_ff : LW'(grow_ff);
   assign fs_ext   = LW'(faddr_ff) - HDR_L;
   assign fslot    = fs_ext >> 3;
   assign rounded  = (ffa_pkg::GROW_W'(rbytes_ff) + 17'd7) & ~17'd7;
   assign prev_hit = (idx_ff != '0) && (prev_s + prev_l == ps_ff);
   assign next_hit = have_cur_ff && (ps_ff + plen_ff == cur_s);

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_st_ff;

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      grow_in     = grow_ff;
      frag_in     = frag_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      kind_in     = kind_ff;
      rbytes_in   = rbytes_ff;
      faddr_in    = faddr_ff;
      need_in     = need_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      blk_s_in    = blk_s_ff;
      blk_len_in  = blk_len_ff;
      glen_in     = glen_ff;
      ps_in       = ps_ff;
      plen_in     = plen_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      have_cur_in = have_cur_ff;
      in_put_in   = in_put_ff;
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ext_we     = 1'b0;
      ext_waddr  = idx_ff[IW-1:0];
      ext_raddr  = idx_ff[IW-1:0];
      ext_wdata  = ext_rd_ff;
      blen_we    = 1'b0;
      live_we    = 1'b0;
      live_wdata = 1'b0;
      slot_waddr = blk_s_ff[SW+2:3];
      slot_raddr = blk_s_ff[SW+2:3];

      // Configuration writes.
      if (csr_write_enable) begin
         unique case (csr_index)
            ffa_pkg::CSR_GROW_MIN: grow_in = csr_write_data[ffa_pkg::GROW_W-1:0];
            ffa_pkg::CSR_MIN_FRAG: frag_in = csr_write_data[ffa_pkg::FRAG_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            live_we    = 1'b1;
            slot_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               rbytes_in = req_request_bytes;
               faddr_in  = req_block_address;
               state_in  = (req_kind == ffa_pkg::KIND_FREE) ? S_F_START : S_A_START;
            end
         end
         S_A_START: begin
            if (rbytes_ff == '0) begin
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_NOMEM;
               state_in    = S_DONE;
            end else begin
               need_in  = LW'(rounded) + HDR_L;
               idx_in   = '0;
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            ext_raddr = idx_ff[IW-1:0];
            state_in  = (idx_ff == count_ff) ? S_A_GROW : S_A_TEST;
         end
         S_A_TEST: begin
            if (rd_len >= need_ff) begin
               blk_s_in = rd_start;
               if (rd_len - need_ff >= thresh) begin
                  // Split: the tail keeps this entry.
                  ext_we     = 1'b1;
                  ext_waddr  = idx_ff[IW-1:0];
                  ext_wdata  = {rd_start + need_ff, rd_len - need_ff};
                  blk_len_in = need_ff;
                  state_in   = S_A_MARK;
               end else begin
                  blk_len_in = rd_len;
                  j_in       = idx_ff;
                  in_put_in  = 1'b0;
                  state_in   = S_D_READ;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_A_SCAN;
            end
         end
         S_A_GROW: begin
            glen_in = glen_c;
            if (top_ff > HEAP_L || glen_c > HEAP_L - top_ff) begin
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_NOMEM;
               state_in    = S_DONE;
            end else begin
               blk_s_in = top_ff;
               if (glen_c - need_ff >= thresh) begin
                  ps_in       = top_ff + need_ff;
                  plen_in     = glen_c - need_ff;
                  blk_len_in  = need_ff;
                  idx_in      = '0;
                  have_cur_in = 1'b0;
                  in_put_in   = 1'b1;
                  state_in    = S_P_SCAN;
               end else begin
                  top_in     = top_ff + glen_c;
                  blk_len_in = glen_c;
                  state_in   = S_A_MARK;
               end
            end
         end
         S_A_MARK: begin
            blen_we     = 1'b1;
            live_we     = 1'b1;
            live_wdata  = 1'b1;
            res_addr_in = ffa_pkg::REQ_W'(blk_s_ff + HDR_L);
            res_st_in   = ffa_pkg::ST_OK;
            state_in    = S_DONE;
         end
         S_F_START: begin
            blk_s_in   = fs_ext;
            slot_raddr = fs_ext[SW+2:3];
            if (faddr_ff[2:0] != 3'd0 || LW'(faddr_ff) < HDR_L || fslot >= SLOTS_L) begin
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_BADFREE;
               state_in    = S_DONE;
            end else begin
               state_in = S_F_CHECK;
            end
         end
         S_F_CHECK: begin
            if (!live_rd_ff) begin
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_BADFREE;
               state_in    = S_DONE;
            end else begin
               ps_in       = blk_s_ff;
               plen_in     = blen_rd_ff;
               idx_in      = '0;
               have_cur_in = 1'b0;
               in_put_in   = 1'b1;
               state_in    = S_P_SCAN;
            end
         end
         S_P_SCAN: begin
            ext_raddr = idx_ff[IW-1:0];
            if (idx_ff == count_ff) begin
               have_cur_in = 1'b0;
               state_in    = S_P_DECIDE;
            end else begin
               state_in = S_P_TEST;
            end
         end
         S_P_TEST: begin
            if (rd_start < ps_ff) begin
               prev_in  = ext_rd_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = S_P_SCAN;
            end else begin
               cur_in      = ext_rd_ff;
               have_cur_in = 1'b1;
               state_in    = S_P_DECIDE;
            end
         end
         S_P_DECIDE: begin
            if (prev_hit && next_hit) begin
               // Bridge two extents, then close the gap.
               ext_we    = 1'b1;
               ext_waddr = IW'(idx_ff - 1'b1);
               ext_wdata = {prev_s, prev_l + plen_ff + cur_l};
               j_in      = idx_ff;
               state_in  = S_D_READ;
            end else if (prev_hit) begin
               ext_we    = 1'b1;
               ext_waddr = IW'(idx_ff - 1'b1);
               ext_wdata = {prev_s, prev_l + plen_ff};
               state_in  = S_P_OK;
            end else if (next_hit) begin
               ext_we    = 1'b1;
               ext_waddr = idx_ff[IW-1:0];
               ext_wdata = {ps_ff, cur_l + plen_ff};
               state_in  = S_P_OK;
            end else if (count_ff == MAX_L) begin
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_FULL;
               state_in    = S_DONE;
            end else begin
               j_in     = count_ff;
               state_in = S_U_READ;
            end
         end
         S_P_OK: begin
            if (kind_ff == ffa_pkg::KIND_ALLOC) begin
               top_in   = blk_s_ff + glen_ff;
               state_in = S_A_MARK;
            end else begin
               live_we     = 1'b1;
               live_wdata  = 1'b0;
               res_addr_in = '0;
               res_st_in   = ffa_pkg::ST_OK;
               state_in    = S_DONE;
            end
         end
         // Move entries down by one, starting at j.
         S_D_READ: begin
            ext_raddr = IW'(j_ff + 1'b1);
            state_in  = (CW'(j_ff + 1'b1) >= count_ff) ? S_D_END : S_D_WRITE;
         end
         S_D_WRITE: begin
            ext_we    = 1'b1;
            ext_waddr = j_ff[IW-1:0];
            ext_wdata = ext_rd_ff;
            j_in      = j_ff + 1'b1;
            state_in  = S_D_READ;
         end
         S_D_END: begin
            count_in = count_ff - 1'b1;
            state_in = in_put_ff ? S_P_OK : S_A_MARK;
         end
         // Move entries up by one, from the end down to idx.
         S_U_READ: begin
            ext_raddr = IW'(j_ff - 1'b1);
            state_in  = (j_ff == idx_ff) ? S_U_END : S_U_WRITE;
         end
         S_U_WRITE: begin
            ext_we    = 1'b1;
            ext_waddr = j_ff[IW-1:0];
            ext_wdata = ext_rd_ff;
            j_in      = j_ff - 1'b1;
            state_in  = S_U_READ;
         end
         S_U_END: begin
            ext_we    = 1'b1;
            ext_waddr = idx_ff[IW-1:0];
            ext_wdata = {ps_ff, plen_ff};
            count_in  = count_ff + 1'b1;
            state_in  = S_P_OK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         grow_ff      <= ffa_pkg::GROW_RESET;
         frag_ff      <= ffa_pkg::FRAG_RESET;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         grow_ff      <= grow_in;
         frag_ff      <= frag_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      rbytes_ff   <= rbytes_in;
      faddr_ff    <= faddr_in;
      need_ff     <= need_in;
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      blk_s_ff    <= blk_s_in;
      blk_len_ff  <= blk_len_in;
      glen_ff     <= glen_in;
      ps_ff       <= ps_in;
      plen_ff     <= plen_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      have_cur_ff <= have_cur_in;
      in_put_ff   <= in_put_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // Extent table memory.
   always_ff @(posedge clock) begin
      if (ext_we) ext_mem[ext_waddr] <= ext_wdata;
      ext_rd_ff <= ext_mem[ext_raddr];
   end

   // Per-slot block length and live mark memories.
   always_ff @(posedge clock) begin
      if (blen_we) blen_mem[slot_waddr] <= blk_len_ff;
      if (live_we) live_mem[slot_waddr] <= live_wdata;
      blen_rd_ff <= blen_mem[slot_raddr];
      live_rd_ff <= live_mem[slot_raddr];
   end

   // The extent table never holds more entries than it has.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_L)
      else $error("extent count beyond table size");

   // The heap top never passes the end of the heap.
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= HEAP_L)
      else $error("heap top beyond heap");

   // An error result carries a zero address.
   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != ffa_pkg::ST_OK) |-> (rsp_addr_ff == '0))
      else $error("error result with nonzero address");

   // A new result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_addr_ff)))
      else $error("pending result overwritten");

endmodule
